FILE: design/tbo_pkg.sv
// Shared widths, types and codes for the triangle/box overlap pipeline.
// No dependencies.
package tbo_pkg;

	localparam int COORD_W = 20;            // input coordinate, signed Q12.8
	localparam int SIZE_W  = 19;            // box size, unsigned Q11.8
	localparam int DIFF_W  = COORD_W + 1;   // vertex/corner differences
	localparam int PT_W    = COORD_W + 2;   // difference plus size, negated edge
	localparam int NPRD_W  = 2 * DIFF_W;    // normal partial product
	localparam int NRM_W   = NPRD_W + 1;    // unnormalized normal component
	localparam int NLO_W   = DIFF_W;        // low slice of the normal
	localparam int NHI_W   = NRM_W - NLO_W; // high slice of the normal
	localparam int PROD_W  = 2 * PT_W;      // 22 x 22 product
	localparam int SUM_W   = PROD_W + 2;    // sum of three products
	localparam int EACC_W  = PROD_W + 1;    // sum of two products
	localparam int ACC_W   = SUM_W + NLO_W + 1;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PT_W-1:0]    pt_t;
	typedef logic signed [NPRD_W-1:0]  nprd_t;
	typedef logic signed [NRM_W-1:0]   nrm_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [EACC_W-1:0]  eacc_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic [SIZE_W-1:0]         size_t;

	typedef logic [1:0] reject_t;
	localparam reject_t REJ_NONE  = 2'd0;
	localparam reject_t REJ_BBOX  = 2'd1;
	localparam reject_t REJ_PLANE = 2'd2;
	localparam reject_t REJ_EDGE  = 2'd3;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_SIZE_X = 2'd0;
	localparam reg_idx_t REG_SIZE_Y = 2'd1;
	localparam reg_idx_t REG_SIZE_Z = 2'd2;

	localparam size_t SIZE_RESET = size_t'(256);

endpackage

FILE: design/triangle_box_overlap.sv
// Triangle/box overlap test: seven-stage pipeline, one query word per cycle.
// Throughput: one word per cycle; done is the stage-7 valid bit.
// busy is always low; the receiver takes done without stalling.
// Reset clears all pipeline valid bits and sets each box size to 1.0 (256).
// Sizes may be rewritten only while no word is in flight.
// Depends on tbo_pkg.
module triangle_box_overlap
	import tbo_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                start,
	output logic                busy,
	input  logic signed [COORD_W-1:0] corner_x,
	input  logic signed [COORD_W-1:0] corner_y,
	input  logic signed [COORD_W-1:0] corner_z,
	input  logic signed [COORD_W-1:0] vert0_x,
	input  logic signed [COORD_W-1:0] vert0_y,
	input  logic signed [COORD_W-1:0] vert0_z,
	input  logic signed [COORD_W-1:0] vert1_x,
	input  logic signed [COORD_W-1:0] vert1_y,
	input  logic signed [COORD_W-1:0] vert1_z,
	input  logic signed [COORD_W-1:0] vert2_x,
	input  logic signed [COORD_W-1:0] vert2_y,
	input  logic signed [COORD_W-1:0] vert2_z,
	output logic                done,
	output logic                overlaps,
	output logic [1:0]          reject_stage
);

	// ---------------- configuration ----------------
	size_t    size_q [3];
	reg_idx_t ridx;
	logic     wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign ridx   = paddr[3:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q[0] <= SIZE_RESET;
			size_q[1] <= SIZE_RESET;
			size_q[2] <= SIZE_RESET;
		end else if (wr_en) begin
			unique case (ridx)
				REG_SIZE_X: size_q[0] <= pwdata[SIZE_W-1:0];
				REG_SIZE_Y: size_q[1] <= pwdata[SIZE_W-1:0];
				REG_SIZE_Z: size_q[2] <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_SIZE_X: prdata = {{(DATA_W-SIZE_W){1'b0}}, size_q[0]};
			REG_SIZE_Y: prdata = {{(DATA_W-SIZE_W){1'b0}}, size_q[1]};
			REG_SIZE_Z: prdata = {{(DATA_W-SIZE_W){1'b0}}, size_q[2]};
			default:    prdata = '0;
		endcase
	end

	// size as a signed point operand
	pt_t sz [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			sz[i] = signed'({{(PT_W-SIZE_W){1'b0}}, size_q[i]});
	end

	// ---------------- stage 1: differences, bounding box ----------------
	coord_t c [3];
	coord_t v [3][3];
	assign c[0] = corner_x;  assign c[1] = corner_y;  assign c[2] = corner_z;
	assign v[0][0] = vert0_x; assign v[0][1] = vert0_y; assign v[0][2] = vert0_z;
	assign v[1][0] = vert1_x; assign v[1][1] = vert1_y; assign v[1][2] = vert1_z;
	assign v[2][0] = vert2_x; assign v[2][1] = vert2_y; assign v[2][2] = vert2_z;

	diff_t e_d [3][3];
	diff_t b_d [3][3];
	logic  bb_d;

	always_comb begin
		coord_t lo, hi;
		diff_t  top;
		bb_d = 1'b0;
		for (int i = 0; i < 3; i++) begin
			lo = v[0][i];
			hi = v[0][i];
			for (int k = 1; k < 3; k++) begin
				if (v[k][i] < lo) lo = v[k][i];
				if (v[k][i] > hi) hi = v[k][i];
			end
			top = diff_t'(c[i]) + signed'({2'b00, size_q[i]});
			if (c[i] > hi || top < diff_t'(lo))
				bb_d = 1'b1;
		end
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				// edge k runs from vertex k to the next vertex
				e_d[k][i] = diff_t'(v[(k == 2) ? 0 : k + 1][i]) - diff_t'(v[k][i]);
				b_d[k][i] = diff_t'(c[i]) - diff_t'(v[k][i]);
			end
		end
	end

	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	diff_t e_s1 [3][3];
	diff_t b_s1 [3][3];
	logic  bb_s1;

	// ---------------- stage 2: normal partial products ----------------
	// n = e0 x (v2 - v0) = e2 x e0 component-wise
	nprd_t pa_s2 [3];
	nprd_t pb_s2 [3];
	diff_t e_s2 [3][3];
	diff_t b_s2 [3][3];
	logic  bb_s2;

	// ---------------- stage 3: normal ----------------
	nrm_t  n_s3 [3];
	diff_t e_s3 [3][3];
	diff_t b_s3 [3][3];
	logic  bb_s3;

	// ---------------- stage 4: multiplier operands ----------------
	logic signed [NHI_W-1:0] nh_s4 [3];
	pt_t   nl_s4 [3];
	pt_t   plo_s4 [3];
	pt_t   phi_s4 [3];
	pt_t   m1_s4 [3][3];
	pt_t   m2_s4 [3][3];
	pt_t   p1_s4 [3][3];
	pt_t   p2_s4 [3][3];
	logic  nz_s4 [3];
	logic  bb_s4;

	// ---------------- stage 5: products ----------------
	prod_t hlo_s5 [3];
	prod_t llo_s5 [3];
	prod_t hhi_s5 [3];
	prod_t lhi_s5 [3];
	prod_t q1_s5 [3][3];
	prod_t q2_s5 [3][3];
	logic  nz_s5 [3];
	logic  bb_s5;

	// ---------------- stage 6: sums ----------------
	sum_t  shlo_s6, sllo_s6, shhi_s6, slhi_s6;
	logic  edge_s6;
	logic  bb_s6;

	// ---------------- stage 7: decision ----------------
	reject_t rej_s7;

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		int a1, a2;
		logic neg;
		logic e_hit;
		diff_t mm1, mm2;
		pt_t   t1, t2;
		acc_t  alo, ahi;
		// stage 1
		e_s1  <= e_d;
		b_s1  <= b_d;
		bb_s1 <= bb_d;
		// stage 2
		for (int i = 0; i < 3; i++) begin
			a1 = (i == 2) ? 0 : i + 1;
			a2 = (i == 0) ? 2 : i - 1;
			pa_s2[i] <= nprd_t'(e_s1[0][a2]) * nprd_t'(e_s1[2][a1]);
			pb_s2[i] <= nprd_t'(e_s1[0][a1]) * nprd_t'(e_s1[2][a2]);
		end
		e_s2  <= e_s1;
		b_s2  <= b_s1;
		bb_s2 <= bb_s1;
		// stage 3
		for (int i = 0; i < 3; i++)
			n_s3[i] <= nrm_t'(pa_s2[i]) - nrm_t'(pb_s2[i]);
		e_s3  <= e_s2;
		b_s3  <= b_s2;
		bb_s3 <= bb_s2;
		// stage 4: corner selection and oriented edge normals
		for (int i = 0; i < 3; i++) begin
			neg = n_s3[i][NRM_W-1];
			nh_s4[i]  <= n_s3[i][NRM_W-1:NLO_W];
			nl_s4[i]  <= signed'({1'b0, n_s3[i][NLO_W-1:0]});
			plo_s4[i] <= pt_t'(b_s3[0][i]) + (neg ? sz[i] : pt_t'(0));
			phi_s4[i] <= pt_t'(b_s3[0][i]) + (neg ? pt_t'(0) : sz[i]);
			nz_s4[i]  <= (n_s3[i] != '0);
		end
		for (int ax = 0; ax < 3; ax++) begin
			a1 = (ax == 2) ? 0 : ax + 1;
			a2 = (ax == 0) ? 2 : ax - 1;
			neg = n_s3[ax][NRM_W-1];
			for (int k = 0; k < 3; k++) begin
				// flip the axis to point away from the opposite vertex
				mm1 = e_s3[k][a2];
				mm2 = e_s3[k][a1];
				t1 = neg ? -pt_t'(mm1) : pt_t'(mm1);
				t2 = neg ? pt_t'(mm2) : -pt_t'(mm2);
				m1_s4[ax][k] <= t1;
				m2_s4[ax][k] <= t2;
				p1_s4[ax][k] <= pt_t'(b_s3[k][a1]) + (t1[PT_W-1] ? sz[a1] : pt_t'(0));
				p2_s4[ax][k] <= pt_t'(b_s3[k][a2]) + (t2[PT_W-1] ? sz[a2] : pt_t'(0));
			end
		end
		bb_s4 <= bb_s3;
		// stage 5
		for (int i = 0; i < 3; i++) begin
			hlo_s5[i] <= prod_t'(nh_s4[i]) * prod_t'(plo_s4[i]);
			llo_s5[i] <= prod_t'(nl_s4[i]) * prod_t'(plo_s4[i]);
			hhi_s5[i] <= prod_t'(nh_s4[i]) * prod_t'(phi_s4[i]);
			lhi_s5[i] <= prod_t'(nl_s4[i]) * prod_t'(phi_s4[i]);
			for (int k = 0; k < 3; k++) begin
				q1_s5[i][k] <= prod_t'(m1_s4[i][k]) * prod_t'(p1_s4[i][k]);
				q2_s5[i][k] <= prod_t'(m2_s4[i][k]) * prod_t'(p2_s4[i][k]);
			end
		end
		nz_s5 <= nz_s4;
		bb_s5 <= bb_s4;
		// stage 6
		shlo_s6 <= sum_t'(hlo_s5[0]) + sum_t'(hlo_s5[1]) + sum_t'(hlo_s5[2]);
		sllo_s6 <= sum_t'(llo_s5[0]) + sum_t'(llo_s5[1]) + sum_t'(llo_s5[2]);
		shhi_s6 <= sum_t'(hhi_s5[0]) + sum_t'(hhi_s5[1]) + sum_t'(hhi_s5[2]);
		slhi_s6 <= sum_t'(lhi_s5[0]) + sum_t'(lhi_s5[1]) + sum_t'(lhi_s5[2]);
		e_hit = 1'b0;
		for (int ax = 0; ax < 3; ax++)
			for (int k = 0; k < 3; k++)
				if (nz_s5[ax] && (eacc_t'(q1_s5[ax][k]) + eacc_t'(q2_s5[ax][k]) > 0))
					e_hit = 1'b1;
		edge_s6 <= e_hit;
		bb_s6 <= bb_s5;
		// stage 7: rebuild the plane sums and pick the first rejection
		alo = (acc_t'(shlo_s6) <<< NLO_W) + acc_t'(sllo_s6);
		ahi = (acc_t'(shhi_s6) <<< NLO_W) + acc_t'(slhi_s6);
		priority if (bb_s6)
			rej_s7 <= REJ_BBOX;
		else if ((alo > 0 && ahi > 0) || (alo < 0 && ahi < 0))
			rej_s7 <= REJ_PLANE;
		else if (edge_s6)
			rej_s7 <= REJ_EDGE;
		else
			rej_s7 <= REJ_NONE;
	end

	assign done         = v_s7;
	assign reject_stage = rej_s7;
	assign overlaps     = (rej_s7 == REJ_NONE);

	// ---------------- assertions ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##7 done)
		else $error("accepted word did not reach done after 7 cycles");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!start ##7 1'b1 |-> !done || $past(v_s1, 6))
		else $error("done raised without an accepted word");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && ridx == REG_SIZE_X) |=> size_q[0] == $past(pwdata[SIZE_W-1:0]))
		else $error("size_x write lost");

endmodule
